// ----- sv/bud_pkg.sv -----
// Shared constants, event codes and types for the byte unstuffing deframer.
package bud_pkg;

    // Receive buffer size; one byte of it is held back, as in the original framing code.
    localparam int BUFFER_SIZE = 1024;

    localparam int COUNT_W = 10;
    localparam int BYTE_W  = 8;
    localparam int EVENT_W = 2;

    // Reset value of max_chars: buffer size minus one, saturated to the register width.
    localparam int MAX_CHARS_FULL = (1 << COUNT_W) - 1;
    localparam logic [COUNT_W-1:0] MAX_CHARS_RESET =
        (BUFFER_SIZE - 1 > MAX_CHARS_FULL) ? COUNT_W'(MAX_CHARS_FULL)
                                           : COUNT_W'(BUFFER_SIZE - 1);

    // Control bytes of the link.
    localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h10;
    localparam logic [BYTE_W-1:0] CR_BYTE  = 8'h0D;
    localparam logic [BYTE_W-1:0] LF_BYTE  = 8'h0A;

    // Event codes of a result.
    localparam logic [EVENT_W-1:0] EV_DATA     = 2'd0;
    localparam logic [EVENT_W-1:0] EV_END      = 2'd1;
    localparam logic [EVENT_W-1:0] EV_RESTART  = 2'd2;
    localparam logic [EVENT_W-1:0] EV_OVERFLOW = 2'd3;

    // One result item.
    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [BYTE_W-1:0]  data_byte;
        logic [COUNT_W-1:0] position;
    } bud_result_t;

    // Deframer state carried from one byte to the next.
    typedef struct packed {
        logic               escape_pending;
        logic [COUNT_W-1:0] byte_count;
    } bud_state_t;

    // Outcome of one byte: whether it makes a result, the result and the new state.
    typedef struct packed {
        logic        res_valid;
        bud_result_t res;
        bud_state_t  state_next;
    } bud_step_t;

endpackage

// ----- sv/bud_step.sv -----
// Per-byte unstuffing decision: classifies one raw byte against the current state.
module bud_step (
    input  logic [bud_pkg::BYTE_W-1:0]  raw_byte,
    input  bud_pkg::bud_state_t         state,
    input  logic [bud_pkg::COUNT_W-1:0] max_chars,
    output bud_pkg::bud_step_t          step
);
    import bud_pkg::*;

    logic is_data;
    logic is_full;

    // A byte is stored as data when it is escaped or is no control byte.
    assign is_data = state.escape_pending ||
                     ((raw_byte != LF_BYTE) && (raw_byte != CR_BYTE) && (raw_byte != ESC_BYTE));
    assign is_full = (state.byte_count >= max_chars);

    always_comb
    begin
        step.res_valid                  = 1'b1;
        step.res.event_res              = EV_DATA;
        step.res.data_byte              = '0;
        step.res.position               = state.byte_count;
        step.state_next.escape_pending  = 1'b0;
        step.state_next.byte_count      = '0;

        if (is_data)
        begin
            // A full frame drops the byte and starts over from zero.
            if (is_full)
            begin
                step.res.event_res = EV_OVERFLOW;
            end
            else
            begin
                step.res.data_byte         = raw_byte;
                step.state_next.byte_count = state.byte_count + COUNT_W'(1);
            end
        end
        else
        begin
            case (raw_byte)
                LF_BYTE:
                begin
                    step.res.event_res = EV_END;
                end
                CR_BYTE:
                begin
                    step.res.event_res = EV_RESTART;
                    step.res.position  = '0;
                end
                default:
                begin
                    // Escape byte: no result, the count is kept for the next byte.
                    step.res_valid                 = 1'b0;
                    step.state_next.escape_pending = 1'b1;
                    step.state_next.byte_count     = state.byte_count;
                end
            endcase
        end
    end

endmodule

// ----- sv/byte_unstuff_deframer_top.sv -----
// Top level of the byte unstuffing deframer: input stage, state and result register.
//
// Channel   Direction  Handshake              Payload
// in        in         in_valid / in_ready    in_byte
// out       out        out_valid / out_ready  event_res, data_byte, position
// cfg       in         cfg_we (no wait)       cfg_wdata (max_chars)
//
// One raw byte is accepted per clock cycle while the output is not stalled.
// The rate is set by the combinational step between the input register and the result register.
// Reset clears the escape flag and the byte count and loads max_chars with its default.
// A stalled result holds the result register; the input register then fills and in_ready drops.
// An escape byte produces no result and leaves the input stage even while the output is stalled.
module byte_unstuff_deframer_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bud_pkg::BYTE_W-1:0]    in_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bud_pkg::EVENT_W-1:0]   event_res,
    output logic [bud_pkg::BYTE_W-1:0]    data_byte,
    output logic [bud_pkg::COUNT_W-1:0]   position,
    input  logic                          cfg_we,
    input  logic [bud_pkg::COUNT_W-1:0]   cfg_wdata
);
    import bud_pkg::*;

    logic                 in_valid_reg;
    logic [BYTE_W-1:0]    in_byte_reg;
    bud_state_t           state_reg;
    logic [COUNT_W-1:0]   max_chars_reg;
    logic                 out_valid_reg;
    bud_result_t          out_res_reg;
    bud_step_t            step;
    logic                 out_free;
    logic                 stage_advance;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_chars_reg <= MAX_CHARS_RESET;
        end
        else if (cfg_we)
        begin
            max_chars_reg <= cfg_wdata;
        end
    end

    // Decision for the byte held in the input register.
    bud_step u_step (
        .raw_byte  (in_byte_reg),
        .state     (state_reg),
        .max_chars (max_chars_reg),
        .step      (step)
    );

    // The held byte moves on when its result has somewhere to go, or it has none.
    assign out_free      = !out_valid_reg || out_ready;
    assign stage_advance = in_valid_reg && (out_free || !step.res_valid);
    assign in_ready      = !in_valid_reg || stage_advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= in_byte;
        end
    end

    // Deframer state, updated once per processed byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (stage_advance)
        begin
            state_reg <= step.state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= stage_advance && step.res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && stage_advance && step.res_valid)
        begin
            out_res_reg <= step.res;
        end
    end

    assign out_valid = out_valid_reg;
    assign event_res = out_res_reg.event_res;
    assign data_byte = out_res_reg.data_byte;
    assign position  = out_res_reg.position;

endmodule

// ----- sv/bud_checker.sv -----
// Port-level checks of the byte unstuffing deframer and their binding to the top level.
module bud_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [bud_pkg::EVENT_W-1:0]   event_res,
    input  logic [bud_pkg::BYTE_W-1:0]    data_byte,
    input  logic [bud_pkg::COUNT_W-1:0]   position
);
    import bud_pkg::*;

    // A stalled result transfer keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res) &&
                                    $stable(data_byte) && $stable(position))
        else $error("result changed while stalled");

    // Only data events carry a byte.
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res != EV_DATA) |-> data_byte == '0)
        else $error("non-data event with a data byte");

    // A restart always reports position zero.
    a_restart_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_RESTART) |-> position == '0)
        else $error("restart with nonzero position");

    // A stored byte index stays below the largest max_chars.
    a_data_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_DATA) |-> position != '1)
        else $error("data byte index out of range");

endmodule

bind byte_unstuff_deframer_top bud_checker u_bud_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .event_res (event_res),
    .data_byte (data_byte),
    .position  (position)
);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the byte unstuffing deframer: directed frames, then random traffic.
module tb_top;
    import bud_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 1000;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_ITEMS  = 64;
    localparam int RANDOM_PHASES = 8;

    // Backpressure styles of the result receiver.
    typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_PERIODIC} ready_mode_e;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [BYTE_W-1:0]  in_byte;
    logic               out_valid;
    logic               out_ready;
    logic [EVENT_W-1:0] event_res;
    logic [BYTE_W-1:0]  data_byte;
    logic [COUNT_W-1:0] position;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_wdata;

    // Deframer state as the testbench predicts it.
    logic               model_escape;
    logic [COUNT_W-1:0] model_count;
    logic [COUNT_W-1:0] model_max_chars;
    bud_result_t        pending_events[$];

    int error_count     = 0;
    int bytes_accepted  = 0;
    int results_checked = 0;
    int settings_used   = 0;
    int event_seen [4]  = '{0, 0, 0, 0};
    int burst_left      = 0;
    bit no_gaps         = 1'b0;

    byte_unstuff_deframer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .event_res (event_res),
        .data_byte (data_byte),
        .position  (position),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Stores one data byte in the predicted frame, or reports an overflow when the frame is full.
    function automatic bud_result_t store_data(input logic [BYTE_W-1:0] b);
        bud_result_t r;
        r = '0;
        if (model_count >= model_max_chars)
        begin
            r.event_res = EV_OVERFLOW;
            r.position  = model_count;
            model_count = '0;
        end
        else
        begin
            r.event_res = EV_DATA;
            r.data_byte = b;
            r.position  = model_count;
            model_count = model_count + COUNT_W'(1);
        end
        return r;
    endfunction

    // Predicts the result of one raw byte and advances the predicted state.
    // Returns 0 when the byte causes no result.
    function automatic logic unstuff_byte(input logic [BYTE_W-1:0] b, output bud_result_t r);
        r = '0;
        if (model_escape)
        begin
            // An escaped byte is always data, whatever its value.
            model_escape = 1'b0;
            r = store_data(b);
            return 1'b1;
        end
        if (b == LF_BYTE)
        begin
            r.event_res = EV_END;
            r.position  = model_count;
            model_count = '0;
            return 1'b1;
        end
        if (b == CR_BYTE)
        begin
            r.event_res = EV_RESTART;
            model_count = '0;
            return 1'b1;
        end
        if (b == ESC_BYTE)
        begin
            model_escape = 1'b1;
            return 1'b0;
        end
        r = store_data(b);
        return 1'b1;
    endfunction

    // At each rising edge, check a result transfer, track register writes and predict
    // from an input transfer.
    always @(posedge clk)
    begin : monitor
        bud_result_t got;
        bud_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = {event_res, data_byte, position};
                if (pending_events.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("ERROR: unexpected result event=%0d data=0x%02h position=%0d",
                                 got.event_res, got.data_byte, got.position);
                end
                else
                begin
                    want = pending_events.pop_front();
                    if (got.event_res !== want.event_res || got.data_byte !== want.data_byte ||
                        got.position !== want.position)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display({"ERROR: result %0d expected event=%0d data=0x%02h ",
                                      "position=%0d, got event=%0d data=0x%02h position=%0d"},
                                     results_checked, want.event_res, want.data_byte,
                                     want.position, got.event_res, got.data_byte, got.position);
                    end
                    event_seen[want.event_res]++;
                    results_checked++;
                end
            end
            if (cfg_we)
                model_max_chars = cfg_wdata;
            if (in_valid && in_ready)
            begin
                bytes_accepted++;
                if (unstuff_byte(in_byte, want))
                    pending_events.push_back(want);
            end
        end
    end

    // Ends the run when no transfer has happened on either channel for too long.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending_events.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result receiver: stretches of steady, random and periodic backpressure.
    initial
    begin : receiver
        ready_mode_e mode;
        int          stretch;
        int          period;
        int          step;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode    = ready_mode_e'($urandom_range(0, 3));
            stretch = $urandom_range(8, 120);
            period  = $urandom_range(2, 12);
            for (step = 0; step < stretch; step++)
            begin
                @(negedge clk);
                case (mode)
                    READY_ALWAYS:  out_ready = 1'b1;
                    READY_MOSTLY:  out_ready = ($urandom_range(0, 3) != 0);
                    READY_RARELY:  out_ready = ($urandom_range(0, 3) == 0);
                    default:       out_ready = (step % period == 0);
                endcase
            end
        end
    end

    // Sends one raw byte as an input transfer. It is called at a falling edge and returns at one;
    // the sender works in bursts with random gaps between them.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid = 1'b1;
        in_byte  = b;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Sends one data byte, stuffing it with an escape when it is a control byte
    // and now and then when it is not.
    task automatic send_data(input logic [BYTE_W-1:0] b);
        if (b == ESC_BYTE || b == CR_BYTE || b == LF_BYTE || $urandom_range(0, 7) == 0)
            send_byte(ESC_BYTE);
        send_byte(b);
    endtask

    // Holds the sender until every predicted result has arrived, then lets the pipeline settle,
    // since a trailing escape byte may still be in flight.
    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending_events.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes max_chars while the block is idle.
    task automatic set_max_chars(input logic [COUNT_W-1:0] value);
        wait_drained();
        cfg_wdata = value;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
        settings_used++;
    endtask

    // Picks a data byte, with control values more often than chance would give them.
    function automatic logic [BYTE_W-1:0] pick_data();
        case ($urandom_range(0, 9))
            0:       return ESC_BYTE;
            1:       return CR_BYTE;
            2:       return LF_BYTE;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Sends a stuffed frame of the given length followed by a terminator byte.
    task automatic send_frame(input int len, input logic [BYTE_W-1:0] terminator);
        repeat (len) send_data(pick_data());
        send_byte(terminator);
    endtask

    // Plain frames, restarts and every escaped control byte at the default limit.
    task automatic test_directed_frames();
        logic [BYTE_W-1:0] seq [14];
        seq = '{8'h00, 8'hFF, LF_BYTE, 8'h41, CR_BYTE, ESC_BYTE, CR_BYTE,
                ESC_BYTE, LF_BYTE, ESC_BYTE, ESC_BYTE, ESC_BYTE, 8'hFF, LF_BYTE};
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    // Overflow with a small limit, an escaped overflow, and a limit of zero.
    task automatic test_directed_overflow();
        logic [BYTE_W-1:0] short_seq [8];
        short_seq = '{8'h01, 8'h02, 8'h03, 8'h04, ESC_BYTE, LF_BYTE, ESC_BYTE, ESC_BYTE};
        set_max_chars(COUNT_W'(2));
        foreach (short_seq[i])
            send_byte(short_seq[i]);
        set_max_chars('0);
        send_byte(8'h7F);
        send_byte(LF_BYTE);
    endtask

    // Fills a frame to the largest limit with plain bytes, all above the control values,
    // so that the count reaches its top value and overflows.
    task automatic test_long_frame();
        set_max_chars(COUNT_W'(MAX_CHARS_FULL));
        send_byte(CR_BYTE);
        repeat (MAX_CHARS_FULL + 1) send_byte(BYTE_W'($urandom_range(32, 255)));
        send_byte(LF_BYTE);
    endtask

    // Random traffic under several limits: mostly well-formed frames, with restarts, noise,
    // broken escapes and pauses until the results have drained.
    task automatic test_random_traffic();
        logic [COUNT_W-1:0] limit;
        int                 target;
        int                 len;
        int                 choice;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       limit = COUNT_W'(MAX_CHARS_FULL);
                1:       limit = '0;
                2:       limit = COUNT_W'(1);
                3:       limit = COUNT_W'($urandom_range(2, 8));
                4:       limit = COUNT_W'($urandom_range(9, 64));
                default: limit = COUNT_W'($urandom_range(0, MAX_CHARS_FULL));
            endcase
            // The count of an unfinished frame carries over into the new limit.
            set_max_chars(limit);
            no_gaps = ($urandom_range(0, 3) == 0);
            target  = bytes_accepted + RANDOM_ITEMS / RANDOM_PHASES;
            while (bytes_accepted < target)
            begin
                len    = $urandom_range(0, (limit < 40) ? int'(limit) + 2 : 40);
                choice = $urandom_range(0, 19);
                if (choice < 14)
                    send_frame(len, LF_BYTE);
                else if (choice < 16)
                    send_frame(len, CR_BYTE);
                else if (choice < 18)
                    repeat ($urandom_range(1, 8)) send_byte(($urandom_range(0, 1) == 0) ?
                        BYTE_W'($urandom_range(0, 255)) : pick_data());
                else if (choice < 19)
                begin
                    // An escaped terminator turns into data and the frame goes on.
                    repeat (len / 2) send_data(pick_data());
                    send_byte(ESC_BYTE);
                    send_byte(($urandom_range(0, 1) == 0) ? LF_BYTE : CR_BYTE);
                end
                else
                    wait_drained();
            end
        end
    endtask

    // Test sequence.
    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_byte         = '0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        model_escape    = 1'b0;
        model_count     = '0;
        model_max_chars = MAX_CHARS_RESET;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_frames();
        test_directed_overflow();
        test_long_frame();
        test_random_traffic();
        wait_drained();

        $display("Sent %0d raw bytes under %0d max_chars settings and checked %0d results.",
                 bytes_accepted, settings_used, results_checked);
        $display("Results: %0d data, %0d frame ends, %0d restarts, %0d overflows; %0d errors.",
                 event_seen[EV_DATA], event_seen[EV_END], event_seen[EV_RESTART],
                 event_seen[EV_OVERFLOW], error_count);
        if (error_count == 0 && pending_events.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
